// ===== rtl/matinv_pkg.sv =====
`default_nettype none

package matinv_pkg;

    // entry format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // derived widths
    localparam int PROD_W = 2 * DATA_WIDTH;            // 2x2 product
    localparam int COF_W  = 2 * DATA_WIDTH + 1;        // exact cofactor
    localparam int LO_W   = DATA_WIDTH + 1;            // low slice of a cofactor
    localparam int HI_W   = COF_W - LO_W;              // high slice of a cofactor
    localparam int DPL_W  = DATA_WIDTH + LO_W + 1;     // row entry times low slice
    localparam int DPH_W  = DATA_WIDTH + HI_W;         // row entry times high slice
    localparam int DET_W  = 3 * DATA_WIDTH + 3;        // exact determinant
    localparam int NUM_W  = COF_W + 2 * FRAC_BITS;     // scaled dividend
    localparam int QB     = DATA_WIDTH + 1;            // quotient bits developed
    localparam int DMAG_W = DET_W - 2 * FRAC_BITS;     // determinant magnitude at output scale

    // pipeline stage positions
    localparam int S_PROD = 0;
    localparam int S_COF  = 1;
    localparam int S_DPRT = 2;
    localparam int S_DPRD = 3;
    localparam int S_DET  = 4;
    localparam int S_ABS  = 5;
    localparam int S_PRE  = 6;
    localparam int S_OUT  = S_PRE + QB + 1;
    localparam int NSTG   = S_OUT + 1;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [COF_W-1:0]      cof_t;
    typedef logic signed [DET_W-1:0]      det_t;
    typedef logic        [DET_W-1:0]      mag_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [DMAG_W-1:0] DMAG_HALF = DMAG_W'(1) << (DATA_WIDTH - 1);
    localparam logic [QB-1:0]     Q_HALF    = QB'(1) << (DATA_WIDTH - 1);

endpackage

`default_nettype wire

// ===== rtl/matrix3_inverse.sv =====
// 3x3 matrix inverse by the adjugate method on signed fixed-point entries
// (Q16.16 with the default package constants). One matrix beat goes in per
// clock and one result beat comes out per clock when nothing stalls. Cofactors
// and the determinant are formed exactly; each of the nine inverse entries
// comes from its own restoring divider pipeline, one quotient bit per stage
// over 33 stages, and that divider depth sets the latency. Each stage holds
// its beat only while the stage after it is full, so bubbles close up and a
// stall on the result side reaches mat_stall only once every stage holds a
// beat. A zero determinant gives singular with all other fields zero; any
// clamped value sets overflow.

`default_nettype none

module matrix3_inverse
(
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    mat_valid,
    output logic                                   mat_stall,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m00,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m01,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m02,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m10,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m11,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m12,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m20,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m21,
    input  wire  signed [matinv_pkg::DATA_WIDTH-1:0] m22,
    output logic                                   res_valid,
    input  wire                                    res_stall,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv00,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv01,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv02,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv10,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv11,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv12,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv20,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv21,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] inv22,
    output logic signed [matinv_pkg::DATA_WIDTH-1:0] determinant,
    output logic                                   singular,
    output logic                                   overflow
);

    localparam int DW     = matinv_pkg::DATA_WIDTH;
    localparam int FB     = matinv_pkg::FRAC_BITS;
    localparam int PROD_W = matinv_pkg::PROD_W;
    localparam int COF_W  = matinv_pkg::COF_W;
    localparam int LO_W   = matinv_pkg::LO_W;
    localparam int DPL_W  = matinv_pkg::DPL_W;
    localparam int DPH_W  = matinv_pkg::DPH_W;
    localparam int DET_W  = matinv_pkg::DET_W;
    localparam int NUM_W  = matinv_pkg::NUM_W;
    localparam int QB     = matinv_pkg::QB;
    localparam int DMAG_W = matinv_pkg::DMAG_W;
    localparam int NSTG   = matinv_pkg::NSTG;

    // matrix entries as nine lanes, row then column
    matinv_pkg::word_t m_in [9];

    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    // ------------------------------------------------------------------
    // stage valids and load enables
    // a stage loads when it is empty or the stage after it also loads
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    assign en[NSTG-1] = !vld_reg[NSTG-1] || !res_stall;

    genvar k;
    generate
        for (k = 0; k < NSTG - 1; k++)
        begin : g_en
            assign en[k] = !vld_reg[k] || en[k+1];
        end
    endgenerate

    always_comb
    begin
        vld_next[0] = en[0] ? mat_valid : vld_reg[0];
        for (int s = 1; s < NSTG; s++)
        begin
            vld_next[s] = en[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign mat_stall = !en[0];
    assign res_valid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // stage S_PROD: the eighteen 2x2 products
    // lane (i, j) holds adjugate entry (i, j), the cofactor of (j, i)
    // ------------------------------------------------------------------
    matinv_pkg::prod_t prod_a_reg  [9];
    matinv_pkg::prod_t prod_b_reg  [9];
    matinv_pkg::prod_t prod_a_next [9];
    matinv_pkg::prod_t prod_b_next [9];
    matinv_pkg::word_t row0a_reg   [3];
    matinv_pkg::word_t row0b_reg   [3];

    genvar l;
    generate
        for (l = 0; l < 9; l++)
        begin : g_prod
            localparam int I  = l / 3;
            localparam int J  = l % 3;
            localparam int R1 = (J + 1) % 3;
            localparam int R2 = (J + 2) % 3;
            localparam int C1 = (I + 1) % 3;
            localparam int C2 = (I + 2) % 3;

            always_comb
            begin
                prod_a_next[l] = PROD_W'(m_in[R1*3+C1]) * PROD_W'(m_in[R2*3+C2]);
                prod_b_next[l] = PROD_W'(m_in[R1*3+C2]) * PROD_W'(m_in[R2*3+C1]);
            end

            always_ff @(posedge clk)
            begin
                if (en[matinv_pkg::S_PROD])
                begin
                    prod_a_reg[l] <= prod_a_next[l];
                    prod_b_reg[l] <= prod_b_next[l];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_PROD])
        begin
            for (int j = 0; j < 3; j++)
            begin
                row0a_reg[j] <= m_in[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage S_COF: exact cofactors
    // ------------------------------------------------------------------
    matinv_pkg::cof_t cof1_reg  [9];
    matinv_pkg::cof_t cof1_next [9];

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            cof1_next[n] = COF_W'(prod_a_reg[n]) - COF_W'(prod_b_reg[n]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_COF])
        begin
            cof1_reg  <= cof1_next;
            row0b_reg <= row0a_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage S_DPRT: row 0 entries times cofactors, split in two slices
    // so that no multiplier is wider than about 32 by 33 bits
    // ------------------------------------------------------------------
    logic signed [DPL_W-1:0] dlo_reg  [3];
    logic signed [DPL_W-1:0] dlo_next [3];
    logic signed [DPH_W-1:0] dhi_reg  [3];
    logic signed [DPH_W-1:0] dhi_next [3];
    matinv_pkg::cof_t        cof2_reg [9];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dlo_next[j] = DPL_W'(row0b_reg[j])
                        * DPL_W'($signed({1'b0, cof1_reg[j*3][LO_W-1:0]}));
            dhi_next[j] = DPH_W'(row0b_reg[j])
                        * DPH_W'($signed(cof1_reg[j*3][COF_W-1:LO_W]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_DPRT])
        begin
            dlo_reg  <= dlo_next;
            dhi_reg  <= dhi_next;
            cof2_reg <= cof1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage S_DPRD: join the slices into three exact products
    // ------------------------------------------------------------------
    matinv_pkg::det_t dp_reg   [3];
    matinv_pkg::det_t dp_next  [3];
    matinv_pkg::cof_t cof3_reg [9];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dp_next[j] = (DET_W'(dhi_reg[j]) <<< LO_W) + DET_W'(dlo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_DPRD])
        begin
            dp_reg   <= dp_next;
            cof3_reg <= cof2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage S_DET: cofactor expansion along row 0
    // ------------------------------------------------------------------
    matinv_pkg::det_t det4_reg;
    matinv_pkg::det_t det4_next;
    matinv_pkg::cof_t cof4_reg [9];

    assign det4_next = dp_reg[0] + dp_reg[1] + dp_reg[2];

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_DET])
        begin
            det4_reg <= det4_next;
            cof4_reg <= cof3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage S_ABS: magnitudes and quotient signs
    // ------------------------------------------------------------------
    logic [COF_W-1:0]  cabs5_reg  [9];
    logic [COF_W-1:0]  cabs5_next [9];
    logic [8:0]        cneg5_reg;
    logic [8:0]        cneg5_next;
    matinv_pkg::mag_t  dabs5_reg;
    matinv_pkg::mag_t  dabs5_next;
    logic              dneg5_reg;
    logic              sing5_reg;

    always_comb
    begin
        dabs5_next = det4_reg[DET_W-1] ? DET_W'(-det4_reg) : DET_W'(det4_reg);
        for (int n = 0; n < 9; n++)
        begin
            cabs5_next[n] = cof4_reg[n][COF_W-1] ? COF_W'(-cof4_reg[n])
                                                  : COF_W'(cof4_reg[n]);
            cneg5_next[n] = cof4_reg[n][COF_W-1] ^ det4_reg[DET_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_ABS])
        begin
            cabs5_reg <= cabs5_next;
            cneg5_reg <= cneg5_next;
            dabs5_reg <= dabs5_next;
            dneg5_reg <= det4_reg[DET_W-1];
            sing5_reg <= (det4_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // divider pipeline: index 0 is the setup stage S_PRE, indexes 1 .. QB
    // each develop one quotient bit for all nine lanes
    // ------------------------------------------------------------------
    logic [DET_W-1:0]   dv_rem_reg  [QB+1][9];
    logic [DET_W-1:0]   dv_rem_next [QB+1][9];
    logic [QB-1:0]      dv_nlo_reg  [QB+1][9];
    logic [QB-1:0]      dv_nlo_next [QB+1][9];
    logic [QB-1:0]      dv_q_reg    [QB+1][9];
    logic [QB-1:0]      dv_q_next   [QB+1][9];
    logic [8:0]         dv_neg_reg  [QB+1];
    logic [8:0]         dv_big_reg  [QB+1];
    logic [8:0]         dv_big_next [QB+1];
    matinv_pkg::mag_t   dv_dabs_reg [QB+1];
    logic               dv_sing_reg [QB+1];
    matinv_pkg::word_t  dv_detq_reg [QB+1];
    matinv_pkg::word_t  detq_next;
    logic               dv_dovf_reg [QB+1];
    logic               dovf_next;
    logic [NUM_W-1:0]   num_w  [9];
    logic [DMAG_W-1:0]  dmag;
    logic [DMAG_W-1:0]  dmag_neg;

    // setup: scale the dividend, seed the remainder with its top bits and
    // flag quotients that already reach 2^QB; also scale the determinant
    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            num_w[n]          = {cabs5_reg[n], {(2*FB){1'b0}}};
            dv_rem_next[0][n] = DET_W'(num_w[n][NUM_W-1:QB]);
            dv_nlo_next[0][n] = num_w[n][QB-1:0];
            dv_q_next[0][n]   = '0;
            dv_big_next[0][n] = (DET_W'(num_w[n][NUM_W-1:QB]) >= dabs5_reg);
        end

        dmag     = dabs5_reg[DET_W-1:2*FB];
        dmag_neg = -dmag;
        if (dneg5_reg)
        begin
            if (dmag > matinv_pkg::DMAG_HALF)
            begin
                detq_next = matinv_pkg::WORD_MIN;
                dovf_next = 1'b1;
            end
            else
            begin
                detq_next = dmag_neg[DW-1:0];
                dovf_next = 1'b0;
            end
        end
        else
        begin
            if (dmag >= matinv_pkg::DMAG_HALF)
            begin
                detq_next = matinv_pkg::WORD_MAX;
                dovf_next = 1'b1;
            end
            else
            begin
                detq_next = dmag[DW-1:0];
                dovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_PRE])
        begin
            dv_rem_reg[0]  <= dv_rem_next[0];
            dv_nlo_reg[0]  <= dv_nlo_next[0];
            dv_q_reg[0]    <= dv_q_next[0];
            dv_big_reg[0]  <= dv_big_next[0];
            dv_neg_reg[0]  <= cneg5_reg;
            dv_dabs_reg[0] <= dabs5_reg;
            dv_sing_reg[0] <= sing5_reg;
            dv_detq_reg[0] <= detq_next;
            dv_dovf_reg[0] <= dovf_next;
        end
    end

    genvar d;
    generate
        for (d = 1; d <= QB; d++)
        begin : g_div
            logic [DET_W:0] trial [9];
            logic [DET_W:0] diff  [9];
            logic [8:0]     ge;

            // restoring step: shift in the next dividend bit, subtract if it fits
            always_comb
            begin
                for (int n = 0; n < 9; n++)
                begin
                    trial[n] = {dv_rem_reg[d-1][n], dv_nlo_reg[d-1][n][QB-1]};
                    diff[n]  = trial[n] - {1'b0, dv_dabs_reg[d-1]};
                    ge[n]    = (trial[n] >= {1'b0, dv_dabs_reg[d-1]});
                    dv_rem_next[d][n] = ge[n] ? diff[n][DET_W-1:0]
                                              : trial[n][DET_W-1:0];
                    dv_q_next[d][n]   = {dv_q_reg[d-1][n][QB-2:0], ge[n]};
                    dv_nlo_next[d][n] = {dv_nlo_reg[d-1][n][QB-2:0], 1'b0};
                end
                dv_big_next[d] = dv_big_reg[d-1];
            end

            always_ff @(posedge clk)
            begin
                if (en[matinv_pkg::S_PRE + d])
                begin
                    dv_rem_reg[d]  <= dv_rem_next[d];
                    dv_nlo_reg[d]  <= dv_nlo_next[d];
                    dv_q_reg[d]    <= dv_q_next[d];
                    dv_big_reg[d]  <= dv_big_next[d];
                    dv_neg_reg[d]  <= dv_neg_reg[d-1];
                    dv_dabs_reg[d] <= dv_dabs_reg[d-1];
                    dv_sing_reg[d] <= dv_sing_reg[d-1];
                    dv_detq_reg[d] <= dv_detq_reg[d-1];
                    dv_dovf_reg[d] <= dv_dovf_reg[d-1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // stage S_OUT: sign, saturation and the singular case
    // ------------------------------------------------------------------
    matinv_pkg::word_t inv_reg  [9];
    matinv_pkg::word_t inv_next [9];
    matinv_pkg::word_t det_reg;
    matinv_pkg::word_t det_next;
    logic              sing_reg;
    logic              ovf_reg;
    logic              ovf_next;
    logic [8:0]        lane_ovf;
    logic [QB-1:0]     qv   [9];
    logic [QB-1:0]     qneg [9];

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            qv[n]   = dv_q_reg[QB][n];
            qneg[n] = -qv[n];
            if (dv_neg_reg[QB][n])
            begin
                if (dv_big_reg[QB][n] || (qv[n] > matinv_pkg::Q_HALF))
                begin
                    inv_next[n] = matinv_pkg::WORD_MIN;
                    lane_ovf[n] = 1'b1;
                end
                else
                begin
                    inv_next[n] = qneg[n][DW-1:0];
                    lane_ovf[n] = 1'b0;
                end
            end
            else
            begin
                if (dv_big_reg[QB][n] || (qv[n] >= matinv_pkg::Q_HALF))
                begin
                    inv_next[n] = matinv_pkg::WORD_MAX;
                    lane_ovf[n] = 1'b1;
                end
                else
                begin
                    inv_next[n] = qv[n][DW-1:0];
                    lane_ovf[n] = 1'b0;
                end
            end
            if (dv_sing_reg[QB])
            begin
                inv_next[n] = '0;
            end
        end

        if (dv_sing_reg[QB])
        begin
            det_next = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            det_next = dv_detq_reg[QB];
            ovf_next = (|lane_ovf) || dv_dovf_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[matinv_pkg::S_OUT])
        begin
            inv_reg  <= inv_next;
            det_reg  <= det_next;
            sing_reg <= dv_sing_reg[QB];
            ovf_reg  <= ovf_next;
        end
    end

    assign inv00       = inv_reg[0];
    assign inv01       = inv_reg[1];
    assign inv02       = inv_reg[2];
    assign inv10       = inv_reg[3];
    assign inv11       = inv_reg[4];
    assign inv12       = inv_reg[5];
    assign inv20       = inv_reg[6];
    assign inv21       = inv_reg[7];
    assign inv22       = inv_reg[8];
    assign determinant = det_reg;
    assign singular    = sing_reg;
    assign overflow    = ovf_reg;

`ifndef ASSERT_OFF
    // input side backs up only when every stage holds a beat
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> (&vld_reg))
        else $error("input stalled with an empty stage");

    // an accepted matrix occupies the first stage on the next edge
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (mat_valid && !mat_stall) |=> vld_reg[matinv_pkg::S_PROD])
        else $error("accepted beat lost at pipeline entry");

    // singular result carries a zero determinant, zero diagonal entries and no overflow
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && singular) |-> (determinant == '0 && !overflow &&
            inv00 == '0 && inv11 == '0 && inv22 == '0))
        else $error("singular result with nonzero fields");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import matinv_pkg::*;

    // wide enough for an exact determinant or a scaled cofactor, with room to spare
    typedef logic signed [191:0] exact_t;

    typedef struct {
        word_t e [9];
    } matrix_t;

    typedef struct {
        word_t inv [9];
        word_t det;
        logic  sing;
        logic  ovf;
    } inverse_t;

    // one directed row: a matrix and, where it is obvious, the typed answer
    typedef struct {
        matrix_t  mat;
        bit       typed;
        inverse_t ans;
    } vector_t;

    localparam word_t ONE       = word_t'(1) <<< FRAC_BITS;
    localparam int    N_RANDOM  = 830;
    localparam int    MAX_CYC   = 600000;
    localparam int    HOLD_AT   = 300;
    localparam int    HOLD_LEN  = 160;
    localparam int    DRAIN_CYC = 80;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  mat_valid = 1'b0;
    logic  mat_stall;
    word_t m [9];
    logic  res_valid;
    logic  res_stall = 1'b0;
    word_t inv_o [9];
    word_t determinant;
    logic  singular;
    logic  overflow;

    inverse_t pending_q [$];
    int       errors = 0;
    int       cycles = 0;
    int       beats_in = 0;
    int       beats_out = 0;
    int       n_sing = 0;
    int       n_ovf = 0;
    bit       quiet = 1'b0;
    bit       hold_req = 1'b0;
    bit       held = 1'b0;

    initial
    begin
        for (int i = 0; i < 9; i++)
        begin
            m[i] = '0;
        end
    end

    always #1 clk = ~clk;

    matrix3_inverse dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .mat_valid   (mat_valid),
        .mat_stall   (mat_stall),
        .m00         (m[0]),
        .m01         (m[1]),
        .m02         (m[2]),
        .m10         (m[3]),
        .m11         (m[4]),
        .m12         (m[5]),
        .m20         (m[6]),
        .m21         (m[7]),
        .m22         (m[8]),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .inv00       (inv_o[0]),
        .inv01       (inv_o[1]),
        .inv02       (inv_o[2]),
        .inv10       (inv_o[3]),
        .inv11       (inv_o[4]),
        .inv12       (inv_o[5]),
        .inv20       (inv_o[6]),
        .inv21       (inv_o[7]),
        .inv22       (inv_o[8]),
        .determinant (determinant),
        .singular    (singular),
        .overflow    (overflow)
    );

    // clamp an exact value to the output word, noting any saturation
    function automatic word_t clamp_word(exact_t v, inout logic ovf);
        exact_t hi;
        exact_t lo;
        hi = exact_t'(WORD_MAX);
        lo = exact_t'(WORD_MIN);
        if (v > hi)
        begin
            ovf = 1'b1;
            return WORD_MAX;
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return WORD_MIN;
        end
        return word_t'(v);
    endfunction

    // adjugate inverse with exact cofactors and determinant
    function automatic inverse_t invert(matrix_t a);
        inverse_t r;
        exact_t   x [3][3];
        exact_t   adj [3][3];
        exact_t   det;
        exact_t   q;
        int       r1, r2, c1, c2;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                x[i][j] = exact_t'(a.e[i*3+j]);
            end
        end
        // adj[i][j] is the cofactor of entry (j,i)
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r1 = (j + 1) % 3;
                r2 = (j + 2) % 3;
                c1 = (i + 1) % 3;
                c2 = (i + 2) % 3;
                adj[i][j] = x[r1][c1] * x[r2][c2] - x[r1][c2] * x[r2][c1];
            end
        end
        det = x[0][0] * adj[0][0] + x[0][1] * adj[1][0] + x[0][2] * adj[2][0];
        r.ovf  = 1'b0;
        r.sing = (det == 0);
        if (r.sing)
        begin
            for (int k = 0; k < 9; k++)
            begin
                r.inv[k] = '0;
            end
            r.det = '0;
            return r;
        end
        // signed division truncates toward zero, as the block does
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                q = (adj[i][j] <<< (2 * FRAC_BITS)) / det;
                r.inv[i*3+j] = clamp_word(q, r.ovf);
            end
        end
        q = det / (exact_t'(1) <<< (2 * FRAC_BITS));
        r.det = clamp_word(q, r.ovf);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on result %0d, %s: got %h, expected %h",
                 beats_out, field, got, want);
    endtask

    // ---------------------------------------------------------------
    // result side: check each accepted beat against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("unexpected result beat at cycle %0d", cycles);
            end
            else
            begin
                want = pending_q.pop_front();
                for (int k = 0; k < 9; k++)
                begin
                    if (inv_o[k] !== want.inv[k])
                    begin
                        report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3),
                                        inv_o[k], want.inv[k]);
                    end
                end
                if (determinant !== want.det)
                begin
                    report_mismatch("determinant", determinant, want.det);
                end
                if (singular !== want.sing)
                begin
                    report_mismatch("singular", singular, want.sing);
                end
                if (overflow !== want.ovf)
                begin
                    report_mismatch("overflow", overflow, want.ovf);
                end
            end
            beats_out++;
        end
    end

    // ---------------------------------------------------------------
    // result-side stall: random, silent in quiet phases, one long hold
    // ---------------------------------------------------------------
    initial
    begin
        int r;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                // long hold-off so the pipeline fills and pushes back on the input
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (quiet)
            begin
                res_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    res_stall <= 1'b0;
                end
                else if (r < 95)
                begin
                    res_stall <= 1'b1;
                end
                else
                begin
                    // a few longer stretches of stall
                    res_stall <= 1'b1;
                    repeat ($urandom_range(4, 25)) @(posedge clk);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // matrix side
    // ---------------------------------------------------------------

    // present one beat (already at a rising edge) and hold it until taken
    task automatic offer(matrix_t a, bit typed, inverse_t ans);
        inverse_t want;
        int r;
        int gap;
        for (int k = 0; k < 9; k++)
        begin
            m[k] <= a.e[k];
        end
        mat_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!(mat_valid && !mat_stall));
        want = typed ? ans : invert(a);
        pending_q.push_back(want);
        beats_in++;
        if (want.sing)
        begin
            n_sing++;
        end
        if (want.ovf)
        begin
            n_ovf++;
        end
        // gap after the beat; valid only drops when a gap follows
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            gap = 0;
        end
        else if (r < 92)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(4, 30);
        end
        if (gap > 0)
        begin
            mat_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic word_t rand_word();
        return word_t'($urandom());
    endfunction

    // entry between -4 and +4, the usual geometry range
    function automatic word_t rand_near();
        return word_t'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t a;
        int      mode;
        int      src;
        int      dst;
        mode = $urandom_range(0, 99);
        for (int k = 0; k < 9; k++)
        begin
            a.e[k] = (mode < 20) ? rand_word() : rand_near();
        end
        if (mode >= 20 && mode < 50)
        begin
            // diagonally heavy: well conditioned
            for (int i = 0; i < 3; i++)
            begin
                a.e[i*4] = a.e[i*4] + ((a.e[i*4] < 0) ? -(8 * ONE) : 8 * ONE);
            end
        end
        else if (mode >= 50 && mode < 62)
        begin
            // singular: repeat a row or a column
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            for (int j = 0; j < 3; j++)
            begin
                if (mode < 56)
                begin
                    a.e[dst*3+j] = a.e[src*3+j];
                end
                else
                begin
                    a.e[j*3+dst] = a.e[j*3+src];
                end
            end
        end
        else if (mode >= 62 && mode < 70)
        begin
            // tiny entries: determinant far below one lsb, huge inverse
            for (int k = 0; k < 9; k++)
            begin
                a.e[k] = word_t'($signed($urandom_range(0, 64)) - 32);
            end
        end
        else if (mode >= 70 && mode < 76)
        begin
            // extremes scattered through the matrix
            for (int k = 0; k < 9; k++)
            begin
                case ($urandom_range(0, 3))
                    0: a.e[k] = WORD_MAX;
                    1: a.e[k] = WORD_MIN;
                    default: ;
                endcase
            end
        end
        return a;
    endfunction

    function automatic matrix_t diag(word_t a, word_t b, word_t c);
        matrix_t r;
        for (int k = 0; k < 9; k++)
        begin
            r.e[k] = '0;
        end
        r.e[0] = a;
        r.e[4] = b;
        r.e[8] = c;
        return r;
    endfunction

    function automatic matrix_t fill(word_t v);
        matrix_t r;
        for (int k = 0; k < 9; k++)
        begin
            r.e[k] = v;
        end
        return r;
    endfunction

    function automatic inverse_t answer(word_t d0, word_t dt, logic sg, logic ov);
        inverse_t r;
        for (int k = 0; k < 9; k++)
        begin
            r.inv[k] = '0;
        end
        r.inv[0] = d0;
        r.inv[4] = d0;
        r.inv[8] = d0;
        r.det    = dt;
        r.sing   = sg;
        r.ovf    = ov;
        return r;
    endfunction

    vector_t  vectors [$];
    inverse_t none;

    initial
    begin
        vector_t v;
        none = answer('0, '0, 1'b0, 1'b0);

        // directed table; typed answers only where they are plain
        v.typed = 1'b1;
        v.mat = diag(ONE, ONE, ONE);
        v.ans = answer(ONE, ONE, 1'b0, 1'b0);
        vectors.push_back(v);
        v.mat = fill('0);
        v.ans = answer('0, '0, 1'b1, 1'b0);
        vectors.push_back(v);
        v.mat = fill(WORD_MAX);
        vectors.push_back(v);
        v.mat = fill(WORD_MIN);
        vectors.push_back(v);
        v.mat = fill(word_t'(-1));
        vectors.push_back(v);
        v.mat = diag(2 * ONE, 2 * ONE, 2 * ONE);
        v.ans = answer(ONE / 2, 8 * ONE, 1'b0, 1'b0);
        vectors.push_back(v);
        v.mat = diag(-ONE, -ONE, -ONE);
        v.ans = answer(-ONE, -ONE, 1'b0, 1'b0);
        vectors.push_back(v);

        // rest checked against the predictor
        v.typed = 1'b0;
        v.ans = none;
        v.mat = diag(WORD_MAX, WORD_MAX, WORD_MAX);      // determinant saturates high
        vectors.push_back(v);
        v.mat = diag(WORD_MIN, WORD_MIN, WORD_MIN);      // saturates low
        vectors.push_back(v);
        v.mat = diag(WORD_MIN, WORD_MAX, word_t'(1));
        vectors.push_back(v);
        v.mat = diag(word_t'(1), word_t'(1), word_t'(1)); // tiny determinant
        vectors.push_back(v);
        v.mat = diag(word_t'(-1), word_t'(1), word_t'(3));
        vectors.push_back(v);
        v.mat = diag(ONE, ONE, word_t'(1));
        vectors.push_back(v);
        v.mat = fill('0);                                // permutation
        v.mat.e[1] = ONE;
        v.mat.e[5] = ONE;
        v.mat.e[6] = ONE;
        vectors.push_back(v);
        v.mat = diag(3 * ONE, 5 * ONE, 7 * ONE);         // inexact quotients
        v.mat.e[1] = -ONE;
        v.mat.e[7] = ONE / 3;
        vectors.push_back(v);
        v.mat = fill(WORD_MAX);
        v.mat.e[0] = WORD_MIN;
        v.mat.e[4] = WORD_MIN;
        vectors.push_back(v);
        v.mat = fill(word_t'(32'h5555_5555));
        v.mat.e[2] = word_t'(32'hAAAA_AAAA);
        v.mat.e[4] = word_t'(32'h0F0F_0F0F);
        vectors.push_back(v);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (vectors[i])
        begin
            offer(vectors[i].mat, vectors[i].typed, vectors[i].ans);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // phases of full rate on both sides every so often
            quiet = ((n / 100) % 3 == 1);
            if (n == HOLD_AT)
            begin
                hold_req = 1'b1;
            end
            offer(rand_matrix(), 1'b0, none);
        end
        mat_valid <= 1'b0;
        quiet = 1'b0;

        wait (pending_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("%0d matrices in, %0d results out; %0d singular, %0d saturated",
                 beats_in, beats_out, n_sing, n_ovf);
        $display("traffic mixed random gaps, full-rate phases and a long result hold");
        if (errors == 0 && pending_q.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/matinv_pkg.sv
rtl/matrix3_inverse.sv
tb/testbench.sv
